@@ src/stbc_pkg.sv @@
// ----------------------------------------------------------------------------
// stbc_pkg
// Types and constants shared by the speaker tone and beep controller.
// ----------------------------------------------------------------------------
`default_nettype none

package stbc_pkg;

    // Command codes carried in the opcode field.
    typedef enum logic [1:0] {
        OP_TONE   = 2'd0,
        OP_STOP   = 2'd1,
        OP_BEEP   = 2'd2,
        OP_UPDATE = 2'd3
    } opcode_t;

    // Controller sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } ctrl_state_t;

    // Frequency limits and timer input clock, in hertz.
    localparam logic [31:0] FREQ_MIN  = 32'd20;
    localparam logic [31:0] FREQ_MAX  = 32'd20000;
    localparam int          CLOCK_W   = 21;
    localparam logic [CLOCK_W-1:0] CLOCK_HZ = 21'd1193182;

    // Widths of the frequency divider operands.
    localparam int FREQ_W    = 15;
    localparam int DIVISOR_W = 16;

    // Millisecond to tick conversion.
    localparam int          DUR_W     = 33;
    localparam logic [32:0] ROUND_ADD = 33'd9;
    localparam int          TICK_W    = 4;
    localparam logic [TICK_W-1:0] TICK_MS = 4'd10;

    // Both speaker gate bits.
    localparam logic [1:0] GATE_MASK = 2'b11;

    // One input item.
    typedef struct packed {
        opcode_t     opcode;
        logic [31:0] frequency;
        logic [31:0] beep_len_ms;
        logic [31:0] now_tick;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [15:0] tone_divisor;
        logic        divisor_loaded;
        logic [1:0]  gate_bits;
        logic        beep_running;
    } status_t;

endpackage

`default_nettype wire

@@ src/speaker_tone_beep_controller.sv @@
// ----------------------------------------------------------------------------
// speaker_tone_beep_controller
// Tone generator divisor and speaker gate control with a timed beep.
//
//   Channel | Signals                        | Carries
//   --------+--------------------------------+------------------------------
//   in      | in_valid, in_ready, in_data    | one command (cmd_t)
//   out     | out_valid, out_ready, out_data | state after it (status_t)
//   cfg     | cfg_valid, cfg_ready, cfg_data | speaker_enabled bit
//
// Tone and beep commands with the speaker enabled pass through ST_RUN from
// transfer to result: the bit-serial divide by ten of the rounded 33-bit
// millisecond count sets the length; the 21-step frequency divider runs
// alongside it. Stop, update and disabled commands go straight to ST_EMIT.
// The result register frees the input side: a new command is taken while the
// previous result waits. Reset clears control state and disables the speaker.
// ----------------------------------------------------------------------------
`default_nettype none

module speaker_tone_beep_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire stbc_pkg::cmd_t    in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output stbc_pkg::status_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);

    // Sequencer and held command.
    stbc_pkg::ctrl_state_t state_reg, state_next;
    stbc_pkg::cmd_t        cmd_reg;
    logic                  run_reg;

    // Architectural state.
    logic                  enabled_reg;
    logic [31:0]           stop_tick_reg, stop_tick_next;
    logic                  armed_reg, armed_next;
    logic [1:0]            gate_reg, gate_next;
    logic [15:0]           divisor_reg, divisor_next;

    // Result register.
    logic                  out_valid_reg;
    stbc_pkg::status_t     out_data_reg, result;

    logic                  accept;
    logic                  commit;
    logic                  needs_div;
    logic [31:0]           freq_clamped;
    logic                  freq_busy, tick_busy;
    logic [15:0]           quotient;
    logic [31:0]           ticks;
    logic [31:0]           since_stop;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign needs_div = enabled_reg && ((in_data.opcode == stbc_pkg::OP_TONE)
                                    || (in_data.opcode == stbc_pkg::OP_BEEP));

    // Clamp the requested frequency into the audible range.
    always_comb
    begin
        freq_clamped = in_data.frequency;
        if (freq_clamped < stbc_pkg::FREQ_MIN)
        begin
            freq_clamped = stbc_pkg::FREQ_MIN;
        end
        if (freq_clamped > stbc_pkg::FREQ_MAX)
        begin
            freq_clamped = stbc_pkg::FREQ_MAX;
        end
    end

    stbc_freq_div u_freq_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && needs_div),
        .frequency (freq_clamped[stbc_pkg::FREQ_W-1:0]),
        .busy      (freq_busy),
        .quotient  (quotient)
    );

    stbc_tick_div u_tick_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept && needs_div),
        .beep_len_ms (in_data.beep_len_ms),
        .busy        (tick_busy),
        .ticks       (ticks)
    );

    // Next state of the sequencer and the handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            stbc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = needs_div ? stbc_pkg::ST_RUN : stbc_pkg::ST_EMIT;
                end
            end
            stbc_pkg::ST_RUN:
            begin
                if (!freq_busy && !tick_busy)
                begin
                    state_next = stbc_pkg::ST_EMIT;
                end
            end
            stbc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = stbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbc_pkg::ST_IDLE;
            end
        endcase
    end

    // Command effect on the speaker state.
    always_comb
    begin
        stop_tick_next = stop_tick_reg;
        armed_next     = armed_reg;
        gate_next      = gate_reg;
        divisor_next   = divisor_reg;
        since_stop     = cmd_reg.now_tick - stop_tick_reg;
        case (cmd_reg.opcode)
            stbc_pkg::OP_TONE:
            begin
                if (run_reg)
                begin
                    divisor_next = quotient;
                    gate_next    = gate_reg | stbc_pkg::GATE_MASK;
                end
            end
            stbc_pkg::OP_STOP:
            begin
                gate_next      = gate_reg & ~stbc_pkg::GATE_MASK;
                armed_next     = 1'b0;
                stop_tick_next = '0;
            end
            stbc_pkg::OP_BEEP:
            begin
                if (run_reg)
                begin
                    divisor_next   = quotient;
                    gate_next      = gate_reg | stbc_pkg::GATE_MASK;
                    stop_tick_next = cmd_reg.now_tick + ticks;
                    armed_next     = 1'b1;
                end
            end
            stbc_pkg::OP_UPDATE:
            begin
                if (armed_reg && !since_stop[31])
                begin
                    gate_next      = gate_reg & ~stbc_pkg::GATE_MASK;
                    armed_next     = 1'b0;
                    stop_tick_next = '0;
                end
            end
            default:
            begin
                gate_next = gate_reg;
            end
        endcase
        result.tone_divisor   = divisor_next;
        result.divisor_loaded = run_reg;
        result.gate_bits      = gate_next;
        result.beep_running   = armed_next;
    end

    // Control and architectural registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stbc_pkg::ST_IDLE;
            enabled_reg   <= 1'b0;
            stop_tick_reg <= '0;
            armed_reg     <= 1'b0;
            gate_reg      <= '0;
            divisor_reg   <= '0;
            out_valid_reg <= 1'b0;
            run_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                enabled_reg <= cfg_data;
            end
            if (accept)
            begin
                run_reg <= needs_div;
            end
            if (commit)
            begin
                stop_tick_reg <= stop_tick_next;
                armed_reg     <= armed_next;
                gate_reg      <= gate_next;
                divisor_reg   <= divisor_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held command and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_data;
        end
        if (commit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ src/stbc_freq_div.sv @@
// ----------------------------------------------------------------------------
// stbc_freq_div
// Bit-serial restoring divider: timer clock divided by the tone frequency,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stbc_freq_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [stbc_pkg::FREQ_W-1:0]      frequency,
    output logic                                  busy,
    output logic [stbc_pkg::DIVISOR_W-1:0]        quotient
);

    localparam int STEPS = stbc_pkg::CLOCK_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int FW    = stbc_pkg::FREQ_W;

    logic                busy_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [STEPS-1:0]    dvd_reg;
    logic [FW-1:0]       dsr_reg;
    logic [FW-1:0]       rem_reg;
    logic [STEPS-1:0]    quo_reg;

    logic [FW:0]         rem_shift;
    logic                fits;
    logic [FW:0]         rem_diff;
    logic [FW-1:0]       rem_next;

    // One restoring step on the current remainder.
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[STEPS-1]};
        fits      = rem_shift >= {1'b0, dsr_reg};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        rem_next  = fits ? rem_diff[FW-1:0] : rem_shift[FW-1:0];
    end

    // Control: run for one step per dividend bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= stbc_pkg::CLOCK_HZ;
            dsr_reg <= frequency;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[STEPS-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[STEPS-2:0], fits};
        end
    end

    // The quotient is at least 59 for clamped input; guard zero anyway.
    always_comb
    begin
        busy     = busy_reg;
        quotient = quo_reg[stbc_pkg::DIVISOR_W-1:0];
        if (quotient == '0)
        begin
            quotient = stbc_pkg::DIVISOR_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ src/stbc_tick_div.sv @@
// ----------------------------------------------------------------------------
// stbc_tick_div
// Bit-serial divide by ten that turns a beep length in milliseconds into
// ticks, rounding up, with a minimum of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module stbc_tick_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] beep_len_ms,
    output logic             busy,
    output logic [31:0]      ticks
);

    localparam int STEPS = stbc_pkg::DUR_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int RW    = stbc_pkg::TICK_W;

    logic                busy_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [STEPS-1:0]    dvd_reg;
    logic [RW-1:0]       rem_reg;
    logic [STEPS-1:0]    quo_reg;

    logic [RW:0]         rem_shift;
    logic                fits;
    logic [RW:0]         rem_diff;
    logic [RW-1:0]       rem_next;

    // One restoring step against the constant ten.
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[STEPS-1]};
        fits      = rem_shift >= {1'b0, stbc_pkg::TICK_MS};
        rem_diff  = rem_shift - {1'b0, stbc_pkg::TICK_MS};
        rem_next  = fits ? rem_diff[RW-1:0] : rem_shift[RW-1:0];
    end

    // Control: one step per bit of the rounded dividend.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The dividend is widened by one bit so the rounding add cannot overflow.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {1'b0, beep_len_ms} + stbc_pkg::ROUND_ADD;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[STEPS-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[STEPS-2:0], fits};
        end
    end

    // A zero-length beep still lasts one tick.
    always_comb
    begin
        busy  = busy_reg;
        ticks = quo_reg[31:0];
        if (ticks == 32'd0)
        begin
            ticks = 32'd1;
        end
    end

endmodule

`default_nettype wire

@@ src/stbc_checker.sv @@
// ----------------------------------------------------------------------------
// stbc_checker
// Port-level checks for the speaker tone and beep controller, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stbc_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire stbc_pkg::status_t out_data
);

    // A stalled result holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // A loaded divisor always comes with the speaker sounding.
    a_loaded_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divisor_loaded |->
            out_data.gate_bits == stbc_pkg::GATE_MASK && out_data.tone_divisor != 16'd0)
        else $error("divisor loaded without sounding gate");

    // An armed beep means the gate bits are on.
    a_beep_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.beep_running |-> out_data.gate_bits == stbc_pkg::GATE_MASK)
        else $error("beep armed with speaker silent");

    // One command at a time: no transfer right after a transfer.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second command taken while busy");

endmodule

bind speaker_tone_beep_controller stbc_checker u_stbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
